// ----- rtl/core/hrv_pkg.sv -----
// Shared types, constants and codes for the HRV time-domain statistics block.
// Used by hrv_front, hrv_back and hrv_time_domain_stats; depends on nothing.
package hrv_pkg;

   localparam int POSITION_WIDTH = 24;
   localparam int COUNT_WIDTH    = 16;
   localparam int SUM_WIDTH      = 40;
   localparam int SQ_WIDTH       = 64;
   localparam int OUT_WIDTH      = 24;
   localparam int RATE_WIDTH     = 12;
   localparam int THR_WIDTH      = 10;
   localparam int PNN_WIDTH      = 15;

   localparam int PROD_WIDTH = SQ_WIDTH + COUNT_WIDTH;
   localparam int MUL_STEPS  = SUM_WIDTH;
   localparam int DEN_WIDTH  = 2 * COUNT_WIDTH + 2 * RATE_WIDTH;
   localparam int NUM_WIDTH  = PROD_WIDTH + 32;
   localparam int QUO_WIDTH  = 2 * OUT_WIDTH;
   localparam int STEP_WIDTH = $clog2(NUM_WIDTH);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [OUT_WIDTH-1:0]   OUT_MAX   = '1;
   localparam logic [PNN_WIDTH-1:0]   PNN_MAX   = 15'd25600;
   localparam logic [RATE_WIDTH-1:0]  RATE_RESET = 12'd360;
   localparam logic [THR_WIDTH-1:0]   THR_RESET  = 10'd50;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLE_RATE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD   = 2'd1;

   typedef struct packed {
      logic [POSITION_WIDTH-1:0] peak_position;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0]   mean_rr;
      logic [OUT_WIDTH-1:0]   sdnn;
      logic [OUT_WIDTH-1:0]   rmssd;
      logic [COUNT_WIDTH-1:0] nn50;
      logic [PNN_WIDTH-1:0]   pnn50;
      logic                   valid_res;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } queue_type;

   typedef struct packed {
      logic [RATE_WIDTH-1:0] fs;
      logic [THR_WIDTH-1:0]  threshold_ms;
   } cfg_type;

   typedef enum logic [3:0] {
      B_IDLE, B_ACC, B_PREP1, B_PREP2, B_PREP3, B_MUL1, B_MUL2, B_VAR,
      B_DIV_LOAD, B_DIV, B_DIV_DONE, B_SQRT, B_OUT
   } back_state_type;

   typedef enum logic [1:0] {J_MEAN, J_SDNN, J_RMSSD, J_PNN} job_type;

endpackage

// ----- rtl/core/hrv_front.sv -----
// Front end of the HRV statistics block: accepts peak items into a two-entry queue.
// Depends on hrv_pkg for the item and queue types.
module hrv_front import hrv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output queue_type q_out,
   input  logic      q_pop
);

   req_type    mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;

   assign req_ready   = (count_ff != 2'd2);
   assign push        = req_valid && req_ready;
   assign pop         = q_pop && (count_ff != 2'd0);
   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.item  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

// ----- rtl/core/hrv_back.sv -----
// Back end of the HRV statistics block: accumulates intervals and, on the last
// peak, runs a serial multiplier, divider and square root. Depends on hrv_pkg.
module hrv_back import hrv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  queue_type q_in,
   output logic      q_pop,
   input  cfg_type   cfg,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   back_state_type state_ff, state_in;
   job_type        job_ff;

   // Record accumulators.
   logic [POSITION_WIDTH-1:0] prev_peak_ff, prev_iv_ff;
   logic [COUNT_WIDTH-1:0]    peaks_ff, cnt_ff;
   logic [SUM_WIDTH-1:0]      sum_ff;
   logic [SQ_WIDTH-1:0]       sqsum_ff, dsq_ff;

   // Item in flight.
   logic [POSITION_WIDTH-1:0] pos_ff, iv_ff, d_ff;
   logic                      last_ff, active_ff, has1_ff, has2_ff;

   // Finalization.
   logic [COUNT_WIDTH-1:0]              n_ff;
   logic                                ok_ff;
   logic [2*RATE_WIDTH-1:0]             fs2_ff;
   logic [COUNT_WIDTH+RATE_WIDTH-1:0]   nfs_ff;
   logic [2*COUNT_WIDTH-1:0]            nm_ff;
   logic [COUNT_WIDTH+2*RATE_WIDTH-1:0] mfs2_ff;
   logic [DEN_WIDTH-1:0]                nmfs2_ff;
   logic [SQ_WIDTH-1:0]                 mul_a_ff;
   logic [MUL_STEPS-1:0]                mul_b_ff;
   logic [PROD_WIDTH-1:0]               prod_ff, prod1_ff;
   logic [STEP_WIDTH-1:0]               step_ff;
   logic [NUM_WIDTH-1:0]                num_ff;
   logic [DEN_WIDTH-1:0]                den_ff, rem_ff;
   logic [QUO_WIDTH-1:0]                quo_ff, sq_x_ff;
   logic                                ovf_ff;
   logic [OUT_WIDTH+1:0]                sq_rem_ff;
   logic [OUT_WIDTH-1:0]                root_ff;
   logic [OUT_WIDTH-1:0]                mean_ff, sdnn_ff, rmssd_ff;
   logic [PNN_WIDTH-1:0]                pnn_ff;
   logic                                rsp_valid_ff;
   rsp_type                             rsp_data_ff;

   // Combinational helpers.
   logic [POSITION_WIDTH-1:0] iv_c, d_c;
   logic [SUM_WIDTH:0]        sum_c;
   logic [SQ_WIDTH:0]         sqsum_c, dsq_c;
   logic                      over_c;
   logic [COUNT_WIDTH-1:0]    n_c, m_c;
   logic [PROD_WIDTH-1:0]     prod_c;
   logic [DEN_WIDTH:0]        rem_sh_c;
   logic                      qbit_c;
   logic [QUO_WIDTH-1:0]      quo_c;
   logic [OUT_WIDTH+3:0]      sq_sh_c, sq_trial_c;
   logic                      sq_take_c;
   logic [OUT_WIDTH-1:0]      root_c;
   logic                      load_out;

   always_comb begin
      iv_c    = q_in.item.peak_position - prev_peak_ff;
      d_c     = (iv_c >= prev_iv_ff) ? (iv_c - prev_iv_ff) : (prev_iv_ff - iv_c);
      sum_c   = {1'b0, sum_ff} + (SUM_WIDTH+1)'(iv_ff);
      sqsum_c = {1'b0, sqsum_ff} + (SQ_WIDTH+1)'(iv_ff * iv_ff);
      dsq_c   = {1'b0, dsq_ff} + (SQ_WIDTH+1)'(d_ff * d_ff);
      over_c  = (34'(d_ff) * 34'd1000) > 34'(cfg.threshold_ms * cfg.fs);
      n_c     = (peaks_ff != '0) ? (peaks_ff - 1'b1) : '0;
      m_c     = n_ff - 1'b1;
      prod_c  = {prod_ff[PROD_WIDTH-2:0], 1'b0}
                + (mul_b_ff[MUL_STEPS-1] ? PROD_WIDTH'(mul_a_ff) : '0);
      rem_sh_c = {rem_ff, num_ff[NUM_WIDTH-1]};
      qbit_c   = rem_sh_c >= {1'b0, den_ff};
      quo_c    = {quo_ff[QUO_WIDTH-2:0], qbit_c};
      sq_sh_c    = {sq_rem_ff, sq_x_ff[QUO_WIDTH-1 -: 2]};
      sq_trial_c = (OUT_WIDTH+4)'({root_ff, 2'b01});
      sq_take_c  = sq_sh_c >= sq_trial_c;
      root_c     = {root_ff[OUT_WIDTH-2:0], sq_take_c};
      load_out   = !rsp_valid_ff || rsp_ready;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      case (state_ff)
         B_IDLE: begin
            q_pop = q_in.valid;
            if (q_in.valid) begin
               state_in = B_ACC;
            end
         end
         B_ACC:   state_in = last_ff ? B_PREP1 : B_IDLE;
         B_PREP1: state_in = B_PREP2;
         B_PREP2: state_in = (n_ff >= COUNT_WIDTH'(3)) ? B_PREP3 : B_OUT;
         B_PREP3: state_in = B_MUL1;
         B_MUL1: begin
            if (step_ff == STEP_WIDTH'(MUL_STEPS - 1)) begin
               state_in = B_MUL2;
            end
         end
         B_MUL2: begin
            if (step_ff == STEP_WIDTH'(MUL_STEPS - 1)) begin
               state_in = B_VAR;
            end
         end
         B_VAR:      state_in = B_DIV_LOAD;
         B_DIV_LOAD: state_in = B_DIV;
         B_DIV: begin
            if (step_ff == STEP_WIDTH'(NUM_WIDTH - 1)) begin
               state_in = B_DIV_DONE;
            end
         end
         B_DIV_DONE: begin
            case (job_ff)
               J_MEAN:  state_in = B_DIV_LOAD;
               J_PNN:   state_in = B_OUT;
               default: state_in = ovf_ff ? B_DIV_LOAD : B_SQRT;
            endcase
         end
         B_SQRT: begin
            if (step_ff == STEP_WIDTH'(OUT_WIDTH - 1)) begin
               state_in = B_DIV_LOAD;
            end
         end
         B_OUT: begin
            if (load_out) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Record accumulators and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_peak_ff <= '0;
         prev_iv_ff   <= '0;
         peaks_ff     <= '0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         dsq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == B_ACC && active_ff) begin
            prev_peak_ff <= pos_ff;
            peaks_ff     <= peaks_ff + 1'b1;
            if (has1_ff) begin
               prev_iv_ff <= iv_ff;
               sum_ff     <= sum_c[SUM_WIDTH] ? '1 : sum_c[SUM_WIDTH-1:0];
               sqsum_ff   <= sqsum_c[SQ_WIDTH] ? '1 : sqsum_c[SQ_WIDTH-1:0];
            end
            if (has2_ff) begin
               dsq_ff <= dsq_c[SQ_WIDTH] ? '1 : dsq_c[SQ_WIDTH-1:0];
               if (over_c && cnt_ff != COUNT_MAX) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
         end
         if (state_ff == B_OUT && load_out) begin
            rsp_valid_ff <= 1'b1;
            prev_peak_ff <= '0;
            prev_iv_ff   <= '0;
            peaks_ff     <= '0;
            cnt_ff       <= '0;
            sum_ff       <= '0;
            sqsum_ff     <= '0;
            dsq_ff       <= '0;
         end
      end
   end

   // Datapath of the serial units.
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            pos_ff    <= q_in.item.peak_position;
            last_ff   <= q_in.item.last;
            iv_ff     <= iv_c;
            d_ff      <= d_c;
            active_ff <= peaks_ff != COUNT_MAX;
            has1_ff   <= peaks_ff != '0;
            has2_ff   <= peaks_ff >= COUNT_WIDTH'(2);
         end
         B_PREP1: begin
            n_ff   <= n_c;
            ok_ff  <= n_c >= COUNT_WIDTH'(3);
            fs2_ff <= cfg.fs * cfg.fs;
         end
         B_PREP2: begin
            nfs_ff  <= n_ff * cfg.fs;
            nm_ff   <= n_ff * m_c;
            mfs2_ff <= m_c * fs2_ff;
         end
         B_PREP3: begin
            nmfs2_ff <= nm_ff * fs2_ff;
            mul_a_ff <= sqsum_ff;
            mul_b_ff <= MUL_STEPS'(n_ff);
            prod_ff  <= '0;
            step_ff  <= '0;
         end
         B_MUL1: begin
            prod_ff  <= prod_c;
            mul_b_ff <= mul_b_ff << 1;
            step_ff  <= step_ff + 1'b1;
            if (step_ff == STEP_WIDTH'(MUL_STEPS - 1)) begin
               prod1_ff <= prod_c;
               mul_a_ff <= SQ_WIDTH'(sum_ff);
               mul_b_ff <= sum_ff;
               prod_ff  <= '0;
               step_ff  <= '0;
            end
         end
         B_MUL2: begin
            prod_ff  <= prod_c;
            mul_b_ff <= mul_b_ff << 1;
            step_ff  <= step_ff + 1'b1;
         end
         B_VAR: begin
            // A negative variance numerator reads as zero.
            prod1_ff <= (prod1_ff >= prod_ff) ? (prod1_ff - prod_ff) : '0;
            job_ff   <= J_MEAN;
         end
         B_DIV_LOAD: begin
            rem_ff  <= '0;
            quo_ff  <= '0;
            ovf_ff  <= 1'b0;
            step_ff <= '0;
            case (job_ff)
               J_MEAN: begin
                  num_ff <= NUM_WIDTH'({sum_ff, 16'b0});
                  den_ff <= DEN_WIDTH'(nfs_ff);
               end
               J_SDNN: begin
                  num_ff <= {prod1_ff, 32'b0};
                  den_ff <= nmfs2_ff;
               end
               J_RMSSD: begin
                  num_ff <= NUM_WIDTH'({dsq_ff, 32'b0});
                  den_ff <= DEN_WIDTH'(mfs2_ff);
               end
               default: begin
                  num_ff <= NUM_WIDTH'(cnt_ff * PNN_MAX);
                  den_ff <= DEN_WIDTH'(m_c);
               end
            endcase
         end
         B_DIV: begin
            rem_ff  <= qbit_c ? DEN_WIDTH'(rem_sh_c - {1'b0, den_ff})
                              : DEN_WIDTH'(rem_sh_c);
            quo_ff  <= quo_c;
            ovf_ff  <= ovf_ff | quo_ff[QUO_WIDTH-1];
            num_ff  <= num_ff << 1;
            step_ff <= step_ff + 1'b1;
         end
         B_DIV_DONE: begin
            sq_x_ff   <= quo_ff;
            sq_rem_ff <= '0;
            root_ff   <= '0;
            step_ff   <= '0;
            case (job_ff)
               J_MEAN: begin
                  mean_ff <= (ovf_ff || quo_ff[QUO_WIDTH-1:OUT_WIDTH] != '0)
                             ? OUT_MAX : quo_ff[OUT_WIDTH-1:0];
                  job_ff  <= J_SDNN;
               end
               J_SDNN: begin
                  if (ovf_ff) begin
                     sdnn_ff <= OUT_MAX;
                     job_ff  <= J_RMSSD;
                  end
               end
               J_RMSSD: begin
                  if (ovf_ff) begin
                     rmssd_ff <= OUT_MAX;
                     job_ff   <= J_PNN;
                  end
               end
               default: begin
                  pnn_ff <= (ovf_ff || quo_ff > QUO_WIDTH'(PNN_MAX))
                            ? PNN_MAX : quo_ff[PNN_WIDTH-1:0];
               end
            endcase
         end
         B_SQRT: begin
            sq_rem_ff <= sq_take_c ? (OUT_WIDTH+2)'(sq_sh_c - sq_trial_c)
                                   : (OUT_WIDTH+2)'(sq_sh_c);
            root_ff   <= root_c;
            sq_x_ff   <= sq_x_ff << 2;
            step_ff   <= step_ff + 1'b1;
            if (step_ff == STEP_WIDTH'(OUT_WIDTH - 1)) begin
               if (job_ff == J_SDNN) begin
                  sdnn_ff <= root_c;
                  job_ff  <= J_RMSSD;
               end else begin
                  rmssd_ff <= root_c;
                  job_ff   <= J_PNN;
               end
            end
         end
         B_OUT: begin
            if (load_out) begin
               if (ok_ff) begin
                  rsp_data_ff.mean_rr   <= mean_ff;
                  rsp_data_ff.sdnn      <= sdnn_ff;
                  rsp_data_ff.rmssd     <= rmssd_ff;
                  rsp_data_ff.nn50      <= cnt_ff;
                  rsp_data_ff.pnn50     <= pnn_ff;
                  rsp_data_ff.valid_res <= 1'b1;
               end else begin
                  rsp_data_ff <= '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/core/hrv_time_domain_stats.sv -----
// Top level of the HRV time-domain statistics block (mean RR, SDNN, RMSSD, NN50,
// pNN50). A peak that is not last passes the idle and accumulate states; a last
// peak of a record of three or more intervals runs the bit-serial 112-step divider
// four times, the 40-step multiplier twice and up to two 24-step square roots. The
// back takes one peak at a time; the queue buffers more. Reset is synchronous and
// clears the queue, the accumulators and the output; registers return to 360 and 50.
module hrv_time_domain_stats import hrv_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [RATE_WIDTH-1:0]      csr_data
);

   // Configuration registers. Writes are always taken; an unknown index is ignored.
   logic [RATE_WIDTH-1:0] sample_rate_ff;
   logic [THR_WIDTH-1:0]  threshold_ff;
   cfg_type               cfg;
   queue_type             queue;
   logic                  q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= RATE_RESET;
         threshold_ff   <= THR_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SAMPLE_RATE: sample_rate_ff <= csr_data;
            CSR_THRESHOLD:   threshold_ff   <= csr_data[THR_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // A sample rate of zero is treated as one so that the divisors never vanish.
   assign cfg.fs           = (sample_rate_ff == '0) ? RATE_WIDTH'(1) : sample_rate_ff;
   assign cfg.threshold_ms = threshold_ff;

   // The front queues peak items; the back accumulates them and finalizes a record
   // when it sees the last flag, stalling the queue while it does so.
   hrv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_out     (queue),
      .q_pop     (q_pop)
   );

   hrv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_in      (queue),
      .q_pop     (q_pop),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A record with too few intervals reports all-zero statistics.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |->
         rsp_data.mean_rr == '0 && rsp_data.sdnn == '0 && rsp_data.rmssd == '0 &&
         rsp_data.nn50 == '0 && rsp_data.pnn50 == '0)
      else $error("invalid result carries nonzero statistics");

   // pNN50 never exceeds one hundred percent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pnn50 <= PNN_MAX)
      else $error("pnn50 above full scale");

   // No successive difference over threshold means a zero pNN50.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.nn50 == '0 |-> rsp_data.pnn50 == '0)
      else $error("pnn50 nonzero without nn50");

endmodule
